// ===== rtl/core/grayscale_sobel_edge_stream_core_defines.svh =====
// Assertion helpers for the Sobel edge stream core
`ifndef GRAYSCALE_SOBEL_EDGE_STREAM_CORE_DEFINES_SVH
`define GRAYSCALE_SOBEL_EDGE_STREAM_CORE_DEFINES_SVH
// implication checked each clock, off during reset
`define GSE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define GSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== rtl/core/gse_pkg.sv =====
package gse_pkg;
  localparam logic [0:0] OP_PIXEL = 1'b0;
  localparam logic [0:0] OP_FLUSH = 1'b1;
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;
  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic       border;
    logic       last;
    logic [7:0] center;
  } gse_tag_t;
endpackage

// ===== rtl/core/gse_line_mem.sv =====
module gse_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== rtl/core/gse_mag.sv =====
// Sobel magnitude: kernels, square sum, then 11-step restoring square root over cycles.
module gse_mag (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [71:0]      win,
  output logic             busy,
  output logic             done,
  output logic [7:0]       edge_out
);
  import gse_pkg::*;

  logic signed [11:0] gx, gy;
  logic signed [11:0] ngx, ngy;
  logic [10:0] gxa, gya;
  logic [7:0]  w [9];
  logic [10:0] gxr, gyr;
  logic        sq_ph;
  logic [3:0]  step;

  always_comb begin
    for (int i = 0; i < 9; i++) w[i] = win[i*8 +: 8];
    gx = ($signed({4'd0, w[2]}) + 12'sd2 * $signed({4'd0, w[5]}) + $signed({4'd0, w[8]}))
       - ($signed({4'd0, w[0]}) + 12'sd2 * $signed({4'd0, w[3]}) + $signed({4'd0, w[6]}));
    gy = ($signed({4'd0, w[6]}) + 12'sd2 * $signed({4'd0, w[7]}) + $signed({4'd0, w[8]}))
       - ($signed({4'd0, w[0]}) + 12'sd2 * $signed({4'd0, w[1]}) + $signed({4'd0, w[2]}));
    ngx = -gx;
    ngy = -gy;
    gxa = gx[11] ? ngx[10:0] : gx[10:0];
    gya = gy[11] ? ngy[10:0] : gy[10:0];
  end

  // One root bit per cycle; square is below 2^21, sqrt below 2^11 but saturates at 255.
  logic [21:0] sqv;
  logic [23:0] rem2;
  logic [11:0] rt;
  logic [23:0] rem_sh;
  logic [23:0] trial;
  logic        fits;
  logic [11:0] rt_next;

  always_comb begin
    rem_sh = {rem2[21:0], sqv[21:20]};
    trial = {10'd0, rt, 2'b01};
    fits = rem_sh >= trial;
    rt_next = {rt[10:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      sq_ph <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sq_ph <= 1'b1;
        gxr <= gxa;
        gyr <= gya;
      end else if (sq_ph) begin
        sq_ph <= 1'b0;
        sqv <= ({11'd0, gxr} * {11'd0, gxr}) + ({11'd0, gyr} * {11'd0, gyr});
        rem2 <= 24'd0;
        rt <= 12'd0;
        step <= 4'd0;
      end else if (busy) begin
        rem2 <= fits ? rem_sh - trial : rem_sh;
        rt <= rt_next;
        sqv <= {sqv[19:0], 2'b00};
        step <= step + 4'd1;
        if (step == 4'd10) begin
          busy <= 1'b0;
          done <= 1'b1;
          edge_out <= (rt_next > 12'd255) ? 8'd0 : PIX_MAX - rt_next[7:0];
        end
      end
    end
  end
endmodule

// ===== rtl/core/grayscale_sobel_edge_stream_core.sv =====
// Streaming 3x3 Sobel edge core. RGB pixels enter in raster order, are turned
// to gray (r+g+b)/3, and pass through two 8-bit line buffers held in
// synchronous RAMs and a 3x3 window. Items are handled one at a time. For an
// interior item, S_READ takes the line buffer read data and writes back, the
// magnitude unit squares the gradients and runs the bit-serial root, S_MAG
// takes the root and S_HOLD holds the result in the output register, where the
// next input transfer is taken in the cycle the result transfers out. Border
// items and items with no result do not wait for the root. Output lags input
// by frame_width+1 items, with frame_width as clamped to 3..MAX_WIDTH; feed
// frame_width+1 flush items (op=1) after each frame.
module grayscale_sobel_edge_stream_core #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4095
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  edge_value,
  output logic        is_border,
  output logic        frame_last,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import gse_pkg::*;
`include "grayscale_sobel_edge_stream_core_defines.svh"

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int NW = $clog2((MAX_WIDTH + 1) * (MAX_HEIGHT + 1));

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MAG, S_HOLD} state_t;
  state_t state;

  logic [10:0] frame_width;
  logic [11:0] frame_height;
  logic [12:0] wcl;
  logic [HW:0] hcl;
  logic [AW:0] col;
  logic [HW:0] row_count;
  logic [NW:0] n_in;
  logic [7:0]  gray;
  logic [7:0]  win [9];
  logic [7:0]  up_q, mid_q;
  logic [AW-1:0] addr;
  gse_tag_t tag;
  logic        emit;
  logic        mstart, mbusy, mdone;
  logic [7:0]  medge;
  logic [71:0] wflat;
  logic [9:0]  rgb_sum;
  logic [18:0] gray_prod;

  // Clamp registers to legal range.
  always_comb begin
    if (frame_width < 11'd3) wcl = 13'd3;
    else if (13'(frame_width) > 13'(MAX_WIDTH)) wcl = 13'(MAX_WIDTH);
    else wcl = 13'(frame_width);
    if (frame_height < 12'd3) hcl = (HW+1)'(3);
    else if (32'(frame_height) > 32'(MAX_HEIGHT)) hcl = (HW+1)'(MAX_HEIGHT);
    else hcl = (HW+1)'(frame_height);
  end

  assign addr = (32'(col) >= 32'(MAX_WIDTH)) ? '0 : col[AW-1:0];
  assign rgb_sum = 10'(red) + 10'(green) + 10'(blue);
  // divide by 3 as x*683 >> 11, exact for sums up to 765
  assign gray_prod = {9'd0, rgb_sum} * 19'd683;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd640;
      frame_height <= 12'd480;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) frame_width <= cfg_data[10:0];
      else frame_height <= cfg_data;
    end
  end

  logic rd_en, wr_en;
  assign rd_en = in_valid && !in_stall;
  assign wr_en = (state == S_READ);

  gse_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_upper (
    .clk(clk), .rd_en(rd_en), .rd_addr(addr), .rd_data(up_q),
    .wr_en(wr_en), .wr_addr(addr), .wr_data(mid_q));
  gse_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_middle (
    .clk(clk), .rd_en(rd_en), .rd_addr(addr), .rd_data(mid_q),
    .wr_en(wr_en), .wr_addr(addr), .wr_data(gray));

  // Window after the shift this item makes.
  logic [7:0] nw [9];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nw[k*3]   = win[k*3+1];
      nw[k*3+1] = win[k*3+2];
    end
    nw[2] = up_q;
    nw[5] = mid_q;
    nw[8] = gray;
    for (int i = 0; i < 9; i++) wflat[i*8 +: 8] = nw[i];
  end

  // Output placement.
  logic [NW+1:0] area;
  logic last_c, emit_c, border_c;
  logic [AW:0] oc;
  logic [HW:0] need;
  always_comb begin
    area = (NW+2)'(wcl) * (NW+2)'(hcl) + (NW+2)'(wcl);
    last_c = (NW+2)'(n_in) >= area;
    emit_c = (NW+2)'(n_in) >= (NW+2)'(wcl) + (NW+2)'(1);
    if (col >= (AW+1)'(1)) begin
      oc = col - (AW+1)'(1);
      need = (HW+1)'(1);
    end else begin
      oc = (AW+1)'(wcl - 13'd1);
      need = (HW+1)'(2);
    end
    if (row_count < need + (HW+1)'(1)) border_c = 1'b1;
    else border_c = (row_count - need >= hcl - (HW+1)'(1)) || (oc == '0) ||
                    (13'(oc) >= wcl - 13'd1);
  end

  assign mstart = (state == S_READ) && emit_c && !border_c;
  assign in_stall = (state != S_IDLE) && !(state == S_HOLD && !out_stall);

  gse_mag u_mag (.clk(clk), .rst(rst), .start(mstart), .win(wflat),
    .busy(mbusy), .done(mdone), .edge_out(medge));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      col <= '0;
      row_count <= '0;
      n_in <= '0;
      for (int i = 0; i < 9; i++) win[i] <= 8'd0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE, S_HOLD: begin
          if (state == S_HOLD && !out_stall) state <= S_IDLE;
          if (in_valid && !in_stall) begin
            gray <= (op == OP_PIXEL) ? gray_prod[18:11] : 8'd0;
            state <= S_READ;
          end
        end
        S_READ: begin
          for (int i = 0; i < 9; i++) win[i] <= nw[i];
          tag.border <= border_c;
          tag.last <= last_c;
          tag.center <= nw[4];
          emit <= emit_c;
          if (last_c) begin
            col <= '0; row_count <= '0; n_in <= '0;
          end else begin
            n_in <= n_in + 1'b1;
            if (13'(col) + 13'd1 >= wcl) begin
              col <= '0; row_count <= row_count + 1'b1;
            end else col <= col + 1'b1;
          end
          state <= S_MAG;
        end
        S_MAG: begin
          if (!emit) state <= S_IDLE;
          else if (tag.border || mdone) begin
            edge_value <= tag.border ? tag.center : medge;
            is_border <= tag.border;
            frame_last <= tag.last;
            out_valid <= 1'b1;
            state <= S_HOLD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GSE_ASSERT_IMP(a_stall_when_busy, state == S_READ || state == S_MAG, in_stall)
  `GSE_ASSERT_IMP(a_hold_valid, state == S_HOLD, out_valid)
  `GSE_ASSERT_NEXT(a_mag_only_interior, mstart, mbusy)
endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gse_pkg::*;

  // Cycles of no transfer on either channel before the run is declared hung.
  // The longest legal quiet stretch is the deliberate receiver hold-off.
  localparam int HANG_LIMIT = 4000;
  localparam int HOLD_OFF   = 300;
  localparam int SETTLE     = 40;   // idle cycles before a register write

  typedef struct packed {
    logic [7:0] value;
    logic       border;
    logic       last;
  } edge_res_t;

  typedef struct packed {
    logic       op;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       typed;   // expected result written in below
    logic [7:0] ev;
    logic       eb;
    logic       el;
  } stim_row_t;

  // Directed frames, both 3x3.
  // Frame one is all white: every output is 255, only the center pixel is
  // interior (zero gradient), and the last flush transfer closes the frame.
  // Frame two has a black left column and a white right column, so the
  // center gradient saturates; its results come from the predictor.
  localparam stim_row_t DIRECTED [26] = '{
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b1, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b1, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b1, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b1, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b0, 1'b0},
    '{OP_FLUSH, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b1, 1'b0},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 1'b1, 1'b0},
    '{OP_FLUSH, 8'd255, 8'd0,   8'd128, 1'b1, 8'd255, 1'b1, 1'b0},
    '{OP_FLUSH, 8'd0,   8'd255, 8'd127, 1'b1, 8'd255, 1'b1, 1'b1},
    '{OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd0,   8'd128, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd0,   8'd255, 8'd127, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd128, 8'd127, 8'd1,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_FLUSH, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_PIXEL;
  logic [7:0]  red = 8'd0;
  logic [7:0]  green = 8'd0;
  logic [7:0]  blue = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  edge_value;
  logic        is_border;
  logic        frame_last;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_WIDTH;
  logic [11:0] cfg_data = 12'd0;

  grayscale_sobel_edge_stream_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_value (edge_value),
    .is_border  (is_border),
    .frame_last (frame_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Edge predictor: own copy of the line buffers, window and raster counters
  // ---------------------------------------------------------------------
  logic [10:0] width_reg  = 11'd640;
  logic [11:0] height_reg = 12'd480;
  logic [7:0]  row_above2 [1024];
  logic [7:0]  row_above1 [1024];
  logic [7:0]  window3 [9];
  int          col_pos, row_pos, frame_pos;
  bit          frame_done;

  edge_res_t   pending_edges [$];
  int          mismatches;
  int          idle_pct, stall_pct;
  int          hold_req;

  initial begin
    foreach (row_above2[i]) begin
      row_above2[i] = 8'd0;
      row_above1[i] = 8'd0;
    end
    foreach (window3[i]) window3[i] = 8'd0;
    col_pos = 0;
    row_pos = 0;
    frame_pos = 0;
    frame_done = 1'b0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
  end

  // out-of-range register values are clamped by the block
  function automatic int eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > 1024) return 1024;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > 4095) return 4095;
    return int'(height_reg);
  endfunction

  function automatic logic [7:0] sobel_edge();
    int gx, gy, sq, mag;
    gx = (int'(window3[2]) + 2 * int'(window3[5]) + int'(window3[8]))
       - (int'(window3[0]) + 2 * int'(window3[3]) + int'(window3[6]));
    gy = (int'(window3[6]) + 2 * int'(window3[7]) + int'(window3[8]))
       - (int'(window3[0]) + 2 * int'(window3[1]) + int'(window3[2]));
    sq = gx * gx + gy * gy;
    mag = 0;
    // floor(sqrt) saturated at 255
    while (mag < 255 && (mag + 1) * (mag + 1) <= sq) mag++;
    return 8'(255 - mag);
  endfunction

  task automatic predict_edge(input logic o, input logic [7:0] r, g, b,
                              output bit produced, output edge_res_t res);
    int w, h, c, n, oc, need;
    logic [7:0] gray, up, mid;
    bit brd, lst;
    w = eff_width();
    h = eff_height();
    gray = (o == OP_FLUSH) ? 8'd0 : 8'((int'(r) + int'(g) + int'(b)) / 3);
    c = (col_pos >= 1024) ? 0 : col_pos;
    n = frame_pos;
    up = row_above2[c];
    mid = row_above1[c];
    for (int k = 0; k < 3; k++) begin
      window3[k * 3]     = window3[k * 3 + 1];
      window3[k * 3 + 1] = window3[k * 3 + 2];
    end
    window3[2] = up;
    window3[5] = mid;
    window3[8] = gray;
    row_above2[c] = mid;
    row_above1[c] = gray;
    lst = (n >= w * h + w);
    produced = (n >= w + 1);
    res = '0;
    if (produced) begin
      // output pixel sits one item behind; column 0 input means the
      // previous row's last column
      if (c >= 1) begin
        oc = c - 1;
        need = 1;
      end else begin
        oc = w - 1;
        need = 2;
      end
      if (row_pos < need + 1) brd = 1'b1;
      else brd = (row_pos - need >= h - 1) || (oc == 0) || (oc >= w - 1);
      res.value = brd ? window3[4] : sobel_edge();
      res.border = brd;
      res.last = lst;
    end
    if (lst) begin
      col_pos = 0;
      row_pos = 0;
      frame_pos = 0;
    end else begin
      frame_pos = n + 1;
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos = c + 1;
      end
    end
    frame_done = lst;
  endtask

  // ---------------------------------------------------------------------
  // Input side: called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------
  task automatic send_pixel(input logic o, input logic [7:0] r, g, b,
                            input logic typed, input edge_res_t typed_res);
    bit produced;
    edge_res_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    red <= r;
    green <= g;
    blue <= b;
    // in_stall read here is its value before the edge
    do @(posedge clk); while (in_stall);
    predict_edge(o, r, g, b, produced, res);
    if (produced) pending_edges.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // sender pause: drop valid, wait for every result, let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 12'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_reg = 11'(val);
    else height_reg = 12'(val);
  endtask

  task automatic set_frame(input int w, input int h);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // One full frame with random content. Pixel region mostly op=0, flush
  // region mostly op=1, with a few transfers of the wrong kind as noise.
  // Optionally change the height partway through the frame.
  task automatic send_frame(input int split_at, input int new_h);
    int k, base, spread;
    logic o;
    logic [7:0] r, g, b;
    k = 0;
    base = $urandom_range(0, 215);
    spread = $urandom_range(0, 1) ? 40 : 255;
    frame_done = 1'b0;
    while (!frame_done) begin
      if (k == split_at) begin
        drain();
        write_reg(REG_HEIGHT, new_h);
      end
      o = (frame_pos < eff_width() * eff_height()) ? OP_PIXEL : OP_FLUSH;
      if ($urandom_range(99) < 5) o = ~o;
      if (spread == 255) begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end else begin
        // smooth region: gradient stays below saturation but for zero gray from op=1 noise
        r = 8'(base + $urandom_range(0, spread));
        g = 8'(base + $urandom_range(0, spread));
        b = 8'(base + $urandom_range(0, spread));
      end
      send_pixel(o, r, g, b, 1'b0, '0);
      k++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall, plus a long hold-off on request
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_req = hold_req - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    edge_res_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: edge=%0d border=%0b last=%0b",
                   edge_value, is_border, frame_last);
      end else begin
        exp_res = pending_edges.pop_front();
        if (edge_value !== exp_res.value || is_border !== exp_res.border ||
            frame_last !== exp_res.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp edge=%0d border=%0b last=%0b, got edge=%0d border=%0b last=%0b",
                     exp_res.value, exp_res.border, exp_res.last,
                     edge_value, is_border, frame_last);
        end
      end
    end
  end

  // hang watchdog: counts cycles with no transfer on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("FAIL grayscale_sobel_edge_stream_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    foreach (DIRECTED[i])
      send_pixel(DIRECTED[i].op, DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b,
                 DIRECTED[i].typed,
                 edge_res_t'{value: DIRECTED[i].ev, border: DIRECTED[i].eb,
                             last: DIRECTED[i].el});

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      if (phase == 0) begin
        // clamping of out-of-range registers
        set_frame(1, 0);
        send_frame(-1, 0);
        // receiver holds off while the sender keeps offering transfers
        set_frame(8, 6);
        hold_req = HOLD_OFF;
        send_frame(-1, 0);
        // height changed partway through a frame, shrinking then growing
        set_frame(5, 5);
        send_frame(12, 3);
        set_frame(5, 4);
        send_frame(9, 6);
      end
      for (int f = 0; f < 8; f++) begin
        set_frame($urandom_range(3, 8), $urandom_range(3, 6));
        send_frame(-1, 0);
      end
    end

    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0 && pending_edges.size() == 0) begin
      $display("PASS grayscale_sobel_edge_stream_core");
    end else begin
      $display("FAIL grayscale_sobel_edge_stream_core");
    end
    $finish;
  end
endmodule

// ===== grayscale_sobel_edge_stream_core.f =====
+incdir+rtl/core
rtl/core/gse_pkg.sv
rtl/core/gse_line_mem.sv
rtl/core/gse_mag.sv
rtl/core/grayscale_sobel_edge_stream_core.sv
verif/testbench.sv
